@@ hw/rtl/wsp_pkg.sv @@
// Package for the WAV stream parser: transaction structs, result and error
// codes, parse phases and chunk tags. No dependencies.
package wsp_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_INFO   = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_NOT_WAV = 2'd1,
    ERR_NO_FMT  = 2'd2,
    ERR_UNSUPP  = 2'd3
  } err_e;

  typedef enum logic [12:0] {
    PH_IDLE    = 13'b0000000000001,
    PH_RIFF    = 13'b0000000000010,
    PH_RSIZE   = 13'b0000000000100,
    PH_WAVE    = 13'b0000000001000,
    PH_FMTID   = 13'b0000000010000,
    PH_FMTSIZE = 13'b0000000100000,
    PH_FMTBODY = 13'b0000001000000,
    PH_SKIP    = 13'b0000010000000,
    PH_PAD     = 13'b0000100000000,
    PH_CID     = 13'b0001000000000,
    PH_CSIZE   = 13'b0010000000000,
    PH_DATA    = 13'b0100000000000,
    PH_DONE    = 13'b1000000000000
  } phase_e;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;
  localparam logic [15:0] BITS_16   = 16'd16;
  localparam logic [15:0] BITS_32   = 16'd32;
  localparam logic [31:0] FMT_BASE  = 32'd16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] sample_value;
    logic [15:0]        channel;
    logic               is_float;
    logic [31:0]        sample_rate;
    logic [15:0]        channel_count;
    logic [15:0]        sample_bits;
    err_e               error_code;
    logic               last;
  } out_t;

endpackage

@@ hw/rtl/wav_stream_parser_core.sv @@
// WAV stream parser: one file byte per transaction in, format, sample and
// error transactions out. Depends on wsp_pkg.
// A result is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one byte per cycle; an output register plus one skid entry lets
// input continue while a result waits, and input stalls only while the skid
// entry is occupied. Reset returns the parse to idle and empties the output.
module wav_stream_parser_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  wsp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output wsp_pkg::out_t out_data_o
);

  wsp_pkg::phase_e phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] asm_q, asm_d;
  logic [31:0] tag_q, tag_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [15:0] chidx_q, chidx_d;
  logic [1:0]  bpos_q, bpos_d;

  logic          out_valid_q, out_valid_d;
  wsp_pkg::out_t out_q, out_d;
  logic          skid_valid_q, skid_valid_d;
  wsp_pkg::out_t skid_q, skid_d;

  logic            acc;
  wsp_pkg::phase_e ph;
  logic [31:0]     cnt;
  logic [31:0]     word;
  logic [31:0]     cnt_dec;
  logic            fld_done;
  logic            wide;
  logic [17:0]     frame;
  logic [15:0]     bits_new;
  logic            fmt_ok;
  logic [16:0]     chidx_inc;
  logic            frame_end;
  logic            isf;
  logic            res_valid;
  wsp_pkg::out_t   res;

  assign acc       = in_valid_i && !in_stall_o;
  assign ph        = in_data_i.file_start ? wsp_pkg::PH_RIFF : phase_q;
  assign cnt       = in_data_i.file_start ? 32'd4 : cnt_q;
  assign word      = {in_data_i.data_byte, asm_q[31:8]};
  assign cnt_dec   = cnt - 32'd1;
  assign fld_done  = (cnt_dec == 32'd0);
  assign wide      = (bits_q == wsp_pkg::BITS_32);
  assign frame     = wide ? {chan_q, 2'b00} : {1'b0, chan_q, 1'b0};
  assign bits_new  = word[31:16];
  assign fmt_ok    = (chan_q != 16'd0) &&
                     (((fmt_q == wsp_pkg::FMT_PCM) &&
                       ((bits_new == wsp_pkg::BITS_16) || (bits_new == wsp_pkg::BITS_32))) ||
                      ((fmt_q == wsp_pkg::FMT_FLOAT) && (bits_new == wsp_pkg::BITS_32)));
  assign chidx_inc = {1'b0, chidx_q} + 17'd1;
  assign frame_end = (chidx_inc >= {1'b0, chan_q});
  assign isf       = (fmt_q == wsp_pkg::FMT_FLOAT);

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    asm_d     = asm_q;
    tag_d     = tag_q;
    fmt_d     = fmt_q;
    chan_d    = chan_q;
    rate_d    = rate_q;
    bits_d    = bits_q;
    chidx_d   = chidx_q;
    bpos_d    = bpos_q;
    res_valid = 1'b0;
    res       = '0;
    if (acc) begin
      phase_d = ph;
      cnt_d   = cnt;
      unique case (ph)
        wsp_pkg::PH_IDLE, wsp_pkg::PH_DONE: begin
        end
        wsp_pkg::PH_SKIP: begin
          cnt_d = cnt_dec;
          if (fld_done) begin
            if (tag_q[0]) begin
              phase_d = wsp_pkg::PH_PAD;
            end else begin
              phase_d = wsp_pkg::PH_CID;
              cnt_d   = 32'd4;
            end
          end
        end
        wsp_pkg::PH_PAD: begin
          phase_d = wsp_pkg::PH_CID;
          cnt_d   = 32'd4;
        end
        wsp_pkg::PH_RIFF: begin
          asm_d = word;
          cnt_d = cnt_dec;
          if (fld_done) begin
            tag_d   = word;
            phase_d = wsp_pkg::PH_RSIZE;
            cnt_d   = 32'd4;
          end
        end
        wsp_pkg::PH_RSIZE: begin
          asm_d = word;
          cnt_d = cnt_dec;
          if (fld_done) begin
            phase_d = wsp_pkg::PH_WAVE;
            cnt_d   = 32'd4;
          end
        end
        wsp_pkg::PH_WAVE: begin
          asm_d = word;
          cnt_d = cnt_dec;
          if (fld_done) begin
            if ((tag_q != wsp_pkg::TAG_RIFF) || (word != wsp_pkg::TAG_WAVE)) begin
              res_valid      = 1'b1;
              res.kind       = wsp_pkg::KIND_ERROR;
              res.error_code = wsp_pkg::ERR_NOT_WAV;
              phase_d        = wsp_pkg::PH_DONE;
            end else begin
              phase_d = wsp_pkg::PH_FMTID;
              cnt_d   = 32'd4;
            end
          end
        end
        wsp_pkg::PH_FMTID: begin
          asm_d = word;
          cnt_d = cnt_dec;
          if (fld_done) begin
            if (word != wsp_pkg::TAG_FMT) begin
              res_valid      = 1'b1;
              res.kind       = wsp_pkg::KIND_ERROR;
              res.error_code = wsp_pkg::ERR_NO_FMT;
              phase_d        = wsp_pkg::PH_DONE;
            end else begin
              phase_d = wsp_pkg::PH_FMTSIZE;
              cnt_d   = 32'd4;
            end
          end
        end
        wsp_pkg::PH_FMTSIZE: begin
          asm_d = word;
          cnt_d = cnt_dec;
          if (fld_done) begin
            tag_d   = word;
            phase_d = wsp_pkg::PH_FMTBODY;
            cnt_d   = wsp_pkg::FMT_BASE;
          end
        end
        wsp_pkg::PH_FMTBODY: begin
          asm_d = word;
          cnt_d = cnt_dec;
          if (cnt_dec == 32'd14) begin
            fmt_d = word[31:16];
          end else if (cnt_dec == 32'd12) begin
            chan_d = word[31:16];
          end else if (cnt_dec == 32'd8) begin
            rate_d = word;
          end else if (fld_done) begin
            bits_d = bits_new;
            if (!fmt_ok) begin
              res_valid      = 1'b1;
              res.kind       = wsp_pkg::KIND_ERROR;
              res.error_code = wsp_pkg::ERR_UNSUPP;
              phase_d        = wsp_pkg::PH_DONE;
            end else if (tag_q > wsp_pkg::FMT_BASE) begin
              phase_d = wsp_pkg::PH_SKIP;
              cnt_d   = tag_q - wsp_pkg::FMT_BASE;
            end else begin
              phase_d = wsp_pkg::PH_CID;
              cnt_d   = 32'd4;
            end
          end
        end
        wsp_pkg::PH_CID: begin
          asm_d = word;
          cnt_d = cnt_dec;
          if (fld_done) begin
            tag_d   = word;
            phase_d = wsp_pkg::PH_CSIZE;
            cnt_d   = 32'd4;
          end
        end
        wsp_pkg::PH_CSIZE: begin
          asm_d = word;
          cnt_d = cnt_dec;
          if (fld_done) begin
            if (tag_q != wsp_pkg::TAG_DATA) begin
              tag_d = word;
              if (word == 32'd0) begin
                phase_d = wsp_pkg::PH_CID;
                cnt_d   = 32'd4;
              end else begin
                phase_d = wsp_pkg::PH_SKIP;
                cnt_d   = word;
              end
            end else begin
              chidx_d           = 16'd0;
              bpos_d            = 2'd0;
              res_valid         = 1'b1;
              res.is_float      = isf;
              res.sample_rate   = rate_q;
              res.channel_count = chan_q;
              res.sample_bits   = bits_q;
              if (word < {14'd0, frame}) begin
                res.kind = wsp_pkg::KIND_EMPTY;
                res.last = 1'b1;
                phase_d  = wsp_pkg::PH_DONE;
              end else begin
                res.kind = wsp_pkg::KIND_INFO;
                phase_d  = wsp_pkg::PH_DATA;
                cnt_d    = word;
              end
            end
          end
        end
        wsp_pkg::PH_DATA: begin
          asm_d  = word;
          cnt_d  = cnt_dec;
          bpos_d = bpos_q + 2'd1;
          if (bpos_q == (wide ? 2'd3 : 2'd1)) begin
            bpos_d           = 2'd0;
            res_valid        = 1'b1;
            res.kind         = wsp_pkg::KIND_SAMPLE;
            res.sample_value = wide ? word : {word[31:16], 16'd0};
            res.channel      = chidx_q;
            res.is_float     = isf;
            chidx_d          = frame_end ? 16'd0 : chidx_inc[15:0];
            if (frame_end && (cnt_dec < {14'd0, frame})) begin
              res.last = 1'b1;
              phase_d  = wsp_pkg::PH_DONE;
            end
          end
        end
        default: begin
          phase_d = wsp_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (!out_stall_i) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_d = res_valid;
      out_d       = res;
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= wsp_pkg::PH_IDLE;
      cnt_q        <= '0;
      chidx_q      <= '0;
      bpos_q       <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      cnt_q        <= cnt_d;
      chidx_q      <= chidx_d;
      bpos_q       <= bpos_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    asm_q  <= asm_d;
    tag_q  <= tag_d;
    fmt_q  <= fmt_d;
    chan_q <= chan_d;
    rate_q <= rate_d;
    bits_q <= bits_d;
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/wsp_checker.sv @@
// Port-level checks for the WAV stream parser, bound into wav_stream_parser_core.
// Depends on wsp_pkg and wav_stream_parser_core.
module wsp_props (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input wsp_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  a_stall_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == wsp_pkg::KIND_ERROR) |->
      (out_data_o.error_code != wsp_pkg::ERR_NONE) && !out_data_o.last)
    else $error("error transaction without code");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == wsp_pkg::KIND_EMPTY) |->
      out_data_o.last && (out_data_o.sample_value == 0) &&
      (out_data_o.channel_count != 16'd0))
    else $error("empty-data transaction malformed");

  a_sample_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == wsp_pkg::KIND_SAMPLE) |->
      (out_data_o.sample_rate == 32'd0) && (out_data_o.channel_count == 16'd0) &&
      (out_data_o.error_code == wsp_pkg::ERR_NONE))
    else $error("sample transaction carries format fields");

endmodule

bind wav_stream_parser_core wsp_props u_wsp_props (.*);
